// ===== src/edf_pkg.sv =====
// package: widths, register indexes and the result record of the two-task edf scheduler
package edf_pkg;

   localparam int TIME_BITS     = 32;
   localparam int JOB_BITS      = 16;
   localparam int OUT_TIME_BITS = 32;
   localparam int OUT_JOB_BITS  = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PERIOD_A = 2'd0,
      CSR_EXEC_A   = 2'd1,
      CSR_PERIOD_B = 2'd2,
      CSR_EXEC_B   = 2'd3
   } csr_index_type;

   localparam logic TASK_A = 1'b0;
   localparam logic TASK_B = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] PERIOD_A_RESET = 16'd10;
   localparam logic [CSR_DATA_BITS-1:0] EXEC_A_RESET   = 16'd2;
   localparam logic [CSR_DATA_BITS-1:0] PERIOD_B_RESET = 16'd15;
   localparam logic [CSR_DATA_BITS-1:0] EXEC_B_RESET   = 16'd3;

   typedef struct packed {
      logic [OUT_TIME_BITS-1:0] slice_time;
      logic                     released_a;
      logic                     released_b;
      logic                     completed;
      logic                     completed_task;
      logic [OUT_JOB_BITS-1:0]  completed_job;
      logic                     started;
      logic                     started_task;
      logic [OUT_JOB_BITS-1:0]  started_job;
      logic [OUT_TIME_BITS-1:0] job_deadline;
      logic                     missed;
      logic                     halted;
   } rsp_type;

endpackage

// ===== src/edf_two_task_scheduler_core.sv =====
// top level: non-preemptive earliest-deadline-first scheduler for two periodic tasks
// One request is one time slice. Each slice is worked out in the cycle the request is
// accepted, by one pass of adds and compares over the scheduler state, and its result is
// registered on the rsp_ side; while not stalled the block runs at one slice per clock.
// A two-entry output stage (result register plus skid register) keeps requests flowing
// while a result waits; req_stall rises only when both are full. A miss halts the
// schedule until a request with restart set. Registers are written through the csr_ port,
// which is always ready; the user must write them while idle; the block never checks.
module edf_two_task_scheduler_core
   import edf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [OUT_TIME_BITS-1:0]  rsp_slice_time,
   output logic                      rsp_released_a,
   output logic                      rsp_released_b,
   output logic                      rsp_completed,
   output logic                      rsp_completed_task,
   output logic [OUT_JOB_BITS-1:0]   rsp_completed_job,
   output logic                      rsp_started,
   output logic                      rsp_started_task,
   output logic [OUT_JOB_BITS-1:0]   rsp_started_job,
   output logic [OUT_TIME_BITS-1:0]  rsp_job_deadline,
   output logic                      rsp_missed,
   output logic                      rsp_halted,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [CSR_DATA_BITS-1:0] period_a_ff, exec_a_ff, period_b_ff, exec_b_ff;

   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TIME_BITS-1:0] release_a_ff, release_a_in, release_b_ff, release_b_in;
   logic                 pending_a_ff, pending_a_in, pending_b_ff, pending_b_in;
   logic [TIME_BITS-1:0] deadline_a_ff, deadline_a_in, deadline_b_ff, deadline_b_in;
   logic [JOB_BITS-1:0]  job_a_ff, job_a_in, job_b_ff, job_b_in;
   logic                 busy_ff, busy_in;
   logic                 run_task_ff, run_task_in;
   logic [JOB_BITS-1:0]  run_job_ff, run_job_in;
   logic [TIME_BITS-1:0] finish_ff, finish_in;
   logic                 stopped_ff, stopped_in;

   logic                 req_accept;
   logic                 miss;
   logic                 pick_b;
   logic [TIME_BITS-1:0] t, dist_a, dist_b, slack, ex;
   rsp_type              res;

   rsp_type rsp_ff, skid_ff;
   logic    rsp_valid_ff, skid_valid_ff;
   logic    out_free;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_a_ff <= PERIOD_A_RESET;
         exec_a_ff   <= EXEC_A_RESET;
         period_b_ff <= PERIOD_B_RESET;
         exec_b_ff   <= EXEC_B_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_PERIOD_A: period_a_ff <= csr_data;
            CSR_EXEC_A:   exec_a_ff   <= csr_data;
            CSR_PERIOD_B: period_b_ff <= csr_data;
            CSR_EXEC_B:   exec_b_ff   <= csr_data;
            default:      period_a_ff <= period_a_ff;
         endcase
      end
   end

   // one slice of scheduling
   always_comb begin
      time_in       = req_restart ? '0 : time_ff;
      release_a_in  = req_restart ? '0 : release_a_ff;
      release_b_in  = req_restart ? '0 : release_b_ff;
      pending_a_in  = req_restart ? 1'b0 : pending_a_ff;
      pending_b_in  = req_restart ? 1'b0 : pending_b_ff;
      deadline_a_in = req_restart ? '0 : deadline_a_ff;
      deadline_b_in = req_restart ? '0 : deadline_b_ff;
      job_a_in      = req_restart ? JOB_BITS'(1) : job_a_ff;
      job_b_in      = req_restart ? JOB_BITS'(1) : job_b_ff;
      busy_in       = req_restart ? 1'b0 : busy_ff;
      run_task_in   = req_restart ? TASK_A : run_task_ff;
      run_job_in    = req_restart ? '0 : run_job_ff;
      finish_in     = req_restart ? '0 : finish_ff;
      stopped_in    = req_restart ? 1'b0 : stopped_ff;

      t      = time_in;
      miss   = 1'b0;
      pick_b = 1'b0;
      dist_a = '0;
      dist_b = '0;
      slack  = '0;
      ex     = '0;
      res    = '0;
      res.slice_time = OUT_TIME_BITS'(t);

      if (stopped_in) begin
         res.halted = 1'b1;
      end else begin
         // release
         if (t == release_a_in) begin
            res.released_a = 1'b1;
            if (pending_a_in) begin
               miss             = 1'b1;
               res.started_task = TASK_A;
               res.started_job  = OUT_JOB_BITS'(job_a_in);
               res.job_deadline = OUT_TIME_BITS'(deadline_a_in);
            end else begin
               pending_a_in  = 1'b1;
               deadline_a_in = t + TIME_BITS'(period_a_ff);
            end
            release_a_in = t + TIME_BITS'(period_a_ff);
         end
         if (t == release_b_in) begin
            res.released_b = 1'b1;
            if (pending_b_in) begin
               if (!miss) begin
                  res.started_task = TASK_B;
                  res.started_job  = OUT_JOB_BITS'(job_b_in);
                  res.job_deadline = OUT_TIME_BITS'(deadline_b_in);
               end
               miss = 1'b1;
            end else begin
               pending_b_in  = 1'b1;
               deadline_b_in = t + TIME_BITS'(period_b_ff);
            end
            release_b_in = t + TIME_BITS'(period_b_ff);
         end

         if (!miss) begin
            // completion
            if (busy_in && t == finish_in) begin
               res.completed      = 1'b1;
               res.completed_task = run_task_in;
               res.completed_job  = OUT_JOB_BITS'(run_job_in);
               busy_in            = 1'b0;
            end
            // start
            if (!busy_in && (pending_a_in || pending_b_in)) begin
               dist_a = deadline_a_in - t;
               dist_b = deadline_b_in - t;
               pick_b = pending_b_in && (!pending_a_in || dist_b <= dist_a);
               slack  = pick_b ? dist_b : dist_a;
               ex     = TIME_BITS'(pick_b ? exec_b_ff : exec_a_ff);
               if (ex == '0) begin
                  ex = TIME_BITS'(1);
               end
               res.started_task = pick_b ? TASK_B : TASK_A;
               res.started_job  = OUT_JOB_BITS'(pick_b ? job_b_in : job_a_in);
               res.job_deadline = OUT_TIME_BITS'(pick_b ? deadline_b_in : deadline_a_in);
               if (ex > slack) begin
                  miss = 1'b1;
               end else begin
                  res.started = 1'b1;
                  busy_in     = 1'b1;
                  run_task_in = pick_b ? TASK_B : TASK_A;
                  run_job_in  = pick_b ? job_b_in : job_a_in;
                  finish_in   = t + ex;
                  if (pick_b) begin
                     pending_b_in = 1'b0;
                     job_b_in     = job_b_in + JOB_BITS'(1);
                  end else begin
                     pending_a_in = 1'b0;
                     job_a_in     = job_a_in + JOB_BITS'(1);
                  end
               end
            end
         end

         if (miss) begin
            res.missed = 1'b1;
            res.halted = 1'b1;
            stopped_in = 1'b1;
         end else begin
            time_in = t + TIME_BITS'(1);
         end
      end
   end

   // scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         release_a_ff  <= '0;
         release_b_ff  <= '0;
         pending_a_ff  <= 1'b0;
         pending_b_ff  <= 1'b0;
         deadline_a_ff <= '0;
         deadline_b_ff <= '0;
         job_a_ff      <= JOB_BITS'(1);
         job_b_ff      <= JOB_BITS'(1);
         busy_ff       <= 1'b0;
         run_task_ff   <= TASK_A;
         run_job_ff    <= '0;
         finish_ff     <= '0;
         stopped_ff    <= 1'b0;
      end else if (req_accept) begin
         time_ff       <= time_in;
         release_a_ff  <= release_a_in;
         release_b_ff  <= release_b_in;
         pending_a_ff  <= pending_a_in;
         pending_b_ff  <= pending_b_in;
         deadline_a_ff <= deadline_a_in;
         deadline_b_ff <= deadline_b_in;
         job_a_ff      <= job_a_in;
         job_b_ff      <= job_b_in;
         busy_ff       <= busy_in;
         run_task_ff   <= run_task_in;
         run_job_ff    <= run_job_in;
         finish_ff     <= finish_in;
         stopped_ff    <= stopped_in;
      end
   end

   // result register and skid register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= req_accept;
         end else begin
            rsp_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
            if (req_accept) begin
               skid_ff <= res;
            end
         end else if (req_accept) begin
            rsp_ff <= res;
         end
      end else if (req_accept) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slice_time     = rsp_ff.slice_time;
   assign rsp_released_a     = rsp_ff.released_a;
   assign rsp_released_b     = rsp_ff.released_b;
   assign rsp_completed      = rsp_ff.completed;
   assign rsp_completed_task = rsp_ff.completed_task;
   assign rsp_completed_job  = rsp_ff.completed_job;
   assign rsp_started        = rsp_ff.started;
   assign rsp_started_task   = rsp_ff.started_task;
   assign rsp_started_job    = rsp_ff.started_job;
   assign rsp_job_deadline   = rsp_ff.job_deadline;
   assign rsp_missed         = rsp_ff.missed;
   assign rsp_halted         = rsp_ff.halted;

   // skid entry only ever sits behind a full result register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result while the result register is empty");

   // a miss halts the schedule
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && res.missed) |=> stopped_ff)
      else $error("miss did not halt the scheduler");

   // halted slices leave time untouched
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && stopped_ff && !req_restart) |=> $stable(time_ff))
      else $error("time advanced while halted");

   // a started job always lands on a free processor
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && res.started) |=> busy_ff)
      else $error("started job left the processor idle");

endmodule

// ===== dv/tb_edf_two_task_scheduler_core.sv =====
// testbench: runs slices through the two-task edf scheduler core and checks every result
`timescale 1ns / 100ps

module tb_edf_two_task_scheduler_core;
   import edf_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;

   class edf_slice_predictor;
      logic [CSR_DATA_BITS-1:0] per_a, cost_a, per_b, cost_b;
      logic [TIME_BITS-1:0]     now_slice, due_a, due_b, dl_a, dl_b, finish_at;
      logic [JOB_BITS-1:0]      jobs_a, jobs_b, run_job;
      logic                     pend_a, pend_b, cpu_busy, run_task, halted_state;
      rsp_type                  expected_slices[$];
      int                       mismatches;

      function new();
         per_a = PERIOD_A_RESET;
         cost_a = EXEC_A_RESET;
         per_b = PERIOD_B_RESET;
         cost_b = EXEC_B_RESET;
         mismatches = 0;
         clear_schedule();
      endfunction

      function void clear_schedule();
         now_slice = '0;
         due_a = '0;
         due_b = '0;
         pend_a = 1'b0;
         pend_b = 1'b0;
         dl_a = '0;
         dl_b = '0;
         jobs_a = JOB_BITS'(1);
         jobs_b = JOB_BITS'(1);
         cpu_busy = 1'b0;
         run_task = TASK_A;
         run_job = '0;
         finish_at = '0;
         halted_state = 1'b0;
      endfunction

      function void apply_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_PERIOD_A: per_a = value;
            CSR_EXEC_A:   cost_a = value;
            CSR_PERIOD_B: per_b = value;
            CSR_EXEC_B:   cost_b = value;
            default: ;
         endcase
      endfunction

      function void note_slice(logic restart);
         rsp_type              r;
         logic [TIME_BITS-1:0] t, da, db, slack, ex, dl;
         logic [JOB_BITS-1:0]  num;
         logic                 miss, pick_b;
         r = '0;
         miss = 1'b0;
         if (restart) clear_schedule();
         t = now_slice;
         r.slice_time = OUT_TIME_BITS'(t);
         if (halted_state) begin
            r.halted = 1'b1;
         end else begin
            if (t == due_a) begin
               r.released_a = 1'b1;
               if (pend_a) begin
                  miss = 1'b1;
                  r.started_task = TASK_A;
                  r.started_job = OUT_JOB_BITS'(jobs_a);
                  r.job_deadline = OUT_TIME_BITS'(dl_a);
               end else begin
                  pend_a = 1'b1;
                  dl_a = t + TIME_BITS'(per_a);
               end
               due_a = t + TIME_BITS'(per_a);
            end
            if (t == due_b) begin
               r.released_b = 1'b1;
               if (pend_b) begin
                  if (!miss) begin
                     r.started_task = TASK_B;
                     r.started_job = OUT_JOB_BITS'(jobs_b);
                     r.job_deadline = OUT_TIME_BITS'(dl_b);
                  end
                  miss = 1'b1;
               end else begin
                  pend_b = 1'b1;
                  dl_b = t + TIME_BITS'(per_b);
               end
               due_b = t + TIME_BITS'(per_b);
            end
            if (!miss) begin
               if (cpu_busy && t == finish_at) begin
                  r.completed = 1'b1;
                  r.completed_task = run_task;
                  r.completed_job = OUT_JOB_BITS'(run_job);
                  cpu_busy = 1'b0;
               end
               if (!cpu_busy && (pend_a || pend_b)) begin
                  da = dl_a - t;
                  db = dl_b - t;
                  pick_b = pend_b && (!pend_a || db <= da);
                  slack = pick_b ? db : da;
                  ex = TIME_BITS'(pick_b ? cost_b : cost_a);
                  if (ex == '0) ex = TIME_BITS'(1);
                  num = pick_b ? jobs_b : jobs_a;
                  dl = pick_b ? dl_b : dl_a;
                  r.started_task = pick_b ? TASK_B : TASK_A;
                  r.started_job = OUT_JOB_BITS'(num);
                  r.job_deadline = OUT_TIME_BITS'(dl);
                  if (ex > slack) begin
                     miss = 1'b1;
                  end else begin
                     r.started = 1'b1;
                     cpu_busy = 1'b1;
                     run_task = pick_b ? TASK_B : TASK_A;
                     run_job = num;
                     finish_at = t + ex;
                     if (pick_b) begin
                        pend_b = 1'b0;
                        jobs_b = jobs_b + JOB_BITS'(1);
                     end else begin
                        pend_a = 1'b0;
                        jobs_a = jobs_a + JOB_BITS'(1);
                     end
                  end
               end
            end
            if (miss) begin
               r.missed = 1'b1;
               r.halted = 1'b1;
               halted_state = 1'b1;
            end else begin
               now_slice = t + TIME_BITS'(1);
            end
         end
         expected_slices.push_back(r);
      endfunction

      function string format_slice(rsp_type s);
         return $sformatf("t=%0d rel=%b%b done=%b/%b/%0d start=%b/%b/%0d dl=%0d miss=%b halt=%b",
                          s.slice_time, s.released_a, s.released_b, s.completed,
                          s.completed_task, s.completed_job, s.started, s.started_task,
                          s.started_job, s.job_deadline, s.missed, s.halted);
      endfunction

      function void check_slice(rsp_type got);
         rsp_type exp;
         string   bad;
         bad = "";
         if (expected_slices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with no request pending: %s", format_slice(got));
            return;
         end
         exp = expected_slices.pop_front();
         if (got.slice_time !== exp.slice_time) bad = {bad, " slice_time"};
         if (got.released_a !== exp.released_a) bad = {bad, " released_a"};
         if (got.released_b !== exp.released_b) bad = {bad, " released_b"};
         if (got.completed !== exp.completed) bad = {bad, " completed"};
         if (got.completed_task !== exp.completed_task) bad = {bad, " completed_task"};
         if (got.completed_job !== exp.completed_job) bad = {bad, " completed_job"};
         if (got.started !== exp.started) bad = {bad, " started"};
         if (got.started_task !== exp.started_task) bad = {bad, " started_task"};
         if (got.started_job !== exp.started_job) bad = {bad, " started_job"};
         if (got.job_deadline !== exp.job_deadline) bad = {bad, " job_deadline"};
         if (got.missed !== exp.missed) bad = {bad, " missed"};
         if (got.halted !== exp.halted) bad = {bad, " halted"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch in%s", bad);
               $display("   expected %s", format_slice(exp));
               $display("   actual   %s", format_slice(got));
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_restart = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [OUT_TIME_BITS-1:0]  rsp_slice_time;
   logic                      rsp_released_a;
   logic                      rsp_released_b;
   logic                      rsp_completed;
   logic                      rsp_completed_task;
   logic [OUT_JOB_BITS-1:0]   rsp_completed_job;
   logic                      rsp_started;
   logic                      rsp_started_task;
   logic [OUT_JOB_BITS-1:0]   rsp_started_job;
   logic [OUT_TIME_BITS-1:0]  rsp_job_deadline;
   logic                      rsp_missed;
   logic                      rsp_halted;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   edf_slice_predictor slice_pred = new();

   int burst_left = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int run_left = 0;
   int idle_cycles = 0;

   edf_two_task_scheduler_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_slice_time     (rsp_slice_time),
      .rsp_released_a     (rsp_released_a),
      .rsp_released_b     (rsp_released_b),
      .rsp_completed      (rsp_completed),
      .rsp_completed_task (rsp_completed_task),
      .rsp_completed_job  (rsp_completed_job),
      .rsp_started        (rsp_started),
      .rsp_started_task   (rsp_started_task),
      .rsp_started_job    (rsp_started_job),
      .rsp_job_deadline   (rsp_job_deadline),
      .rsp_missed         (rsp_missed),
      .rsp_halted         (rsp_halted),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      int pick;
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
         run_left = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            rsp_stall <= 1'b1;
            run_left = $urandom_range(0, 5);
         end else if (pick < 8) begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(0, 14);
         end else begin
            rsp_stall <= 1'b0;
            run_left = $urandom_range(30, 80);
         end
      end
   end

   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            slice_pred.apply_register(csr_index_type'(csr_index), csr_data);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            slice_pred.note_slice(req_restart);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            slice_pred.check_slice({rsp_slice_time, rsp_released_a, rsp_released_b,
                                    rsp_completed, rsp_completed_task, rsp_completed_job,
                                    rsp_started, rsp_started_task, rsp_started_job,
                                    rsp_job_deadline, rsp_missed, rsp_halted});
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_BITS-1:0] pa, ea, pb, eb);
      csr_write(CSR_PERIOD_A, pa);
      csr_write(CSR_EXEC_A, ea);
      csr_write(CSR_PERIOD_B, pb);
      csr_write(CSR_EXEC_B, eb);
      csr_valid <= 1'b0;
   endtask

   // one slice request in bursts with random gaps
   task automatic drive_slice(input logic restart);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      burst_left = 0;
      while (slice_pred.expected_slices.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] pa, ea, pb, eb;
      logic                     restart;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: both released, a first, then b
      drive_slice(1'b1);
      repeat (6) drive_slice(1'b0);
      finish_phase();

      // deadline tie goes to b
      write_settings(16'd6, 16'd2, 16'd6, 16'd2);
      drive_slice(1'b1);
      repeat (4) drive_slice(1'b0);
      finish_phase();

      // zero period and zero exec, start miss then halted slice
      write_settings(16'd0, 16'd0, 16'hffff, 16'hffff);
      drive_slice(1'b1);
      drive_slice(1'b0);
      drive_slice(1'b1);
      drive_slice(1'b0);
      finish_phase();

      // release miss of b while a runs long
      write_settings(16'd20, 16'd10, 16'd4, 16'd1);
      drive_slice(1'b1);
      repeat (9) drive_slice(1'b0);
      finish_phase();

      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) begin
            pa = 16'hffff; ea = 16'hffff; pb = 16'd1; eb = 16'd1;
         end else if (ph == 1) begin
            pa = 16'd1; ea = 16'd1; pb = 16'hffff; eb = 16'd0;
         end else begin
            pa = CSR_DATA_BITS'($urandom_range(2, 40));
            pb = CSR_DATA_BITS'($urandom_range(2, 40));
            ea = CSR_DATA_BITS'($urandom_range(0, (ph % 2) ? pa / 3 : pa));
            eb = CSR_DATA_BITS'($urandom_range(0, (ph % 2) ? pb / 3 : pb));
         end
         write_settings(pa, ea, pb, eb);
         for (int n = 0; n < 110; n++) begin
            if (ph == 5 && n == 30) hold_asked++;
            if (slice_pred.halted_state) restart = ($urandom_range(0, 2) == 0);
            else restart = ($urandom_range(0, 149) == 0);
            drive_slice(restart);
         end
         finish_phase();
      end

      repeat (8) @(negedge clock);
      if (slice_pred.mismatches == 0 && slice_pred.expected_slices.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
